// ===== design/sspd_pkg.sv =====
// Package for the sampled serial packet deserializer.
// Holds the result codes, register map constants and the sample and result types.
// No dependencies; imported by the engine, the top level, the checker and the testbench.
`default_nettype none

package sspd_pkg;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_DROP = 2'd2;

    // Register index as seen on paddr[2] (registers lie at 4-byte steps).
    localparam logic       REG_DEGLITCH_COUNT = 1'b0;
    localparam logic [7:0] DEGLITCH_RESET     = 8'd5;

    typedef struct packed {
        logic clock_line;
        logic data_line;
        logic packet_line;
    } t_sample;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [6:0] byte_index;
        logic [7:0] packet_length;
    } t_result;

endpackage

`default_nettype wire

// ===== design/sspd_if.sv =====
// Valid/ready channel interfaces for the sample stream and the result stream.
// Stand-alone; used by the top level of the deserializer.
`default_nettype none

interface sspd_in_if;
    logic valid;
    logic ready;
    logic clock_line;
    logic data_line;
    logic packet_line;

    modport source (output valid, output clock_line, output data_line, output packet_line,
                    input ready);
    modport sink   (input valid, input clock_line, input data_line, input packet_line,
                    output ready);
endinterface

interface sspd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [6:0] byte_index;
    logic [7:0] packet_length;

    modport source (output valid, output kind, output data_byte, output byte_index,
                    output packet_length, input ready);
    modport sink   (input valid, input kind, input data_byte, input byte_index,
                    input packet_length, output ready);
endinterface

`default_nettype wire

// ===== design/sspd_engine.sv =====
// Per-sample engine: edge detection, clock deglitch, bit accumulator and byte counter.
// Depends on sspd_pkg; state advances only on a processed sample.
`default_nettype none

module sspd_engine #(
    parameter int MAX_PACKET_BYTES = 128
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire sspd_pkg::t_sample i_sample,
    input  wire logic [7:0]       i_deglitch_count,
    output logic                  o_result_valid,
    output sspd_pkg::t_result     o_result
);
    import sspd_pkg::*;

    localparam int CW = $clog2(MAX_PACKET_BYTES + 1);
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_PACKET_BYTES);

    logic          r_prev_clock, n_prev_clock;
    logic          r_prev_packet, n_prev_packet;
    logic          r_filtered_clock, n_filtered_clock;
    logic [7:0]    r_countdown, n_countdown;
    logic          r_awaiting_first, n_awaiting_first;
    logic [2:0]    r_bit_count, n_bit_count;
    logic [7:0]    r_shift_byte, n_shift_byte;
    logic [CW-1:0] r_byte_count, n_byte_count;

    logic          w_rise;
    logic          w_fall;
    logic          w_proceed;
    logic [2:0]    w_bit_base;
    logic [7:0]    w_shift_base;
    logic [7:0]    w_shift_new;
    logic [CW+7:0] w_count_ext;

    assign w_rise       = !r_prev_packet && i_sample.packet_line;
    assign w_fall       = r_prev_packet && !i_sample.packet_line;
    assign w_bit_base   = w_rise ? 3'd0 : r_bit_count;
    assign w_shift_base = w_rise ? 8'd0 : r_shift_byte;
    assign w_shift_new  = w_shift_base
                        | (8'({7'd0, i_sample.data_line}) << (3'd7 - w_bit_base));
    assign w_count_ext  = {8'd0, r_byte_count};

    always_comb begin
        n_prev_clock     = r_prev_clock;
        n_prev_packet    = r_prev_packet;
        n_filtered_clock = r_filtered_clock;
        n_countdown      = r_countdown;
        n_awaiting_first = r_awaiting_first;
        n_bit_count      = w_bit_base;
        n_shift_byte     = w_shift_base;
        n_byte_count     = r_byte_count;
        w_proceed        = 1'b0;
        o_result_valid   = 1'b0;
        o_result         = '0;

        if (w_fall && (r_byte_count != '0)) begin
            o_result_valid         = 1'b1;
            o_result.kind          = KIND_END;
            o_result.packet_length = w_count_ext[7:0];
            n_byte_count           = '0;
            n_prev_clock           = i_sample.clock_line;
            n_prev_packet          = 1'b0;
        end else if (!i_sample.packet_line) begin
            n_prev_clock  = i_sample.clock_line;
            n_prev_packet = 1'b0;
        end else if (r_awaiting_first) begin
            // First high sample only seeds the filter; prev_packet stays low.
            n_filtered_clock = i_sample.clock_line;
            n_prev_clock     = i_sample.clock_line;
            n_awaiting_first = 1'b0;
        end else begin
            w_proceed = 1'b1;
            if (i_sample.clock_line != r_filtered_clock) begin
                if (r_countdown == 8'd0) begin
                    n_countdown = i_deglitch_count;
                    w_proceed   = 1'b0;
                end else begin
                    n_countdown = r_countdown - 8'd1;
                    if (r_countdown != 8'd1) begin
                        w_proceed = 1'b0;
                    end else begin
                        n_filtered_clock = i_sample.clock_line;
                    end
                end
            end
        end

        if (w_proceed) begin
            if (!r_prev_clock && i_sample.clock_line) begin
                if (w_bit_base == 3'd7) begin
                    o_result_valid     = 1'b1;
                    o_result.data_byte = w_shift_new;
                    if (r_byte_count >= MAX_COUNT) begin
                        o_result.kind = KIND_DROP;
                    end else begin
                        o_result.kind       = KIND_BYTE;
                        o_result.byte_index = w_count_ext[6:0];
                        n_byte_count        = r_byte_count + CW'(1);
                    end
                    n_bit_count  = 3'd0;
                    n_shift_byte = 8'd0;
                end else begin
                    n_bit_count  = w_bit_base + 3'd1;
                    n_shift_byte = w_shift_new;
                end
            end
            n_prev_clock  = i_sample.clock_line;
            n_prev_packet = i_sample.packet_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_clock     <= 1'b0;
            r_prev_packet    <= 1'b0;
            r_filtered_clock <= 1'b0;
            r_countdown      <= 8'd0;
            r_awaiting_first <= 1'b1;
            r_bit_count      <= 3'd0;
            r_shift_byte     <= 8'd0;
            r_byte_count     <= '0;
        end else if (i_fire) begin
            r_prev_clock     <= n_prev_clock;
            r_prev_packet    <= n_prev_packet;
            r_filtered_clock <= n_filtered_clock;
            r_countdown      <= n_countdown;
            r_awaiting_first <= n_awaiting_first;
            r_bit_count      <= n_bit_count;
            r_shift_byte     <= n_shift_byte;
            r_byte_count     <= n_byte_count;
        end
    end

endmodule

`default_nettype wire

// ===== design/sampled_serial_packet_deserializer.sv =====
// Sampled serial packet deserializer: one oversampled wire sample per beat in, at most
// one result beat out per sample. Throughput is one sample every cycle while the result
// register is free or being emptied. A sample sits in the input register while the
// single-pass engine works on it, and its result, if any, is loaded into the result
// register as the sample is processed. A full result register that is not being taken
// holds back the next sample. The deglitch count is written over the APB
// port at byte address 0 and must only be changed while the block is idle.
// Depends on sspd_pkg, sspd_if and sspd_engine.
`default_nettype none

module sampled_serial_packet_deserializer #(
    parameter int MAX_PACKET_BYTES = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    sspd_in_if.sink          i_in,
    sspd_out_if.source       o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import sspd_pkg::*;

    // Configuration register. Only one register exists, so the word index is paddr[2]
    // and the byte offset bits are ignored.
    logic [7:0] r_deglitch_count;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DEGLITCH_COUNT) ? {24'd0, r_deglitch_count} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deglitch_count <= DEGLITCH_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_DEGLITCH_COUNT)) begin
            r_deglitch_count <= pwdata[7:0];
        end
    end

    // Result register, declared here because the input side looks at it.
    logic    r_out_valid;
    t_result r_out;

    // Input register. It refills in the same cycle it drains, so samples flow at one
    // per cycle whenever the result register is free or being emptied.
    logic    r_s1_valid;
    t_sample r_s1_sample;
    logic    w_out_free;
    logic    w_fire;
    logic    w_in_take;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_fire     = r_s1_valid && w_out_free;
    assign i_in.ready = !r_s1_valid || w_out_free;
    assign w_in_take  = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_take) begin
            r_s1_valid <= 1'b1;
        end else if (w_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_s1_sample.clock_line  <= i_in.clock_line;
            r_s1_sample.data_line   <= i_in.data_line;
            r_s1_sample.packet_line <= i_in.packet_line;
        end
    end

    // The engine holds all packet state and advances only when a sample is processed.
    logic    w_res_valid;
    t_result w_result;

    sspd_engine #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_engine (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (w_fire),
        .i_sample         (r_s1_sample),
        .i_deglitch_count (r_deglitch_count),
        .o_result_valid   (w_res_valid),
        .o_result         (w_result)
    );

    // A processed sample that gives no result simply leaves the result register empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= w_res_valid;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_res_valid) begin
            r_out <= w_result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_out.kind;
    assign o_out.data_byte     = r_out.data_byte;
    assign o_out.byte_index    = r_out.byte_index;
    assign o_out.packet_length = r_out.packet_length;

endmodule

`default_nettype wire

// ===== design/sspd_checker.sv =====
// Port-level checker for the sampled serial packet deserializer, with its bind.
// Depends on sspd_pkg; watches the result channel of the top level only.
`default_nettype none

module sspd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       i_ready,
    input wire logic [1:0] i_kind,
    input wire logic [7:0] i_data_byte,
    input wire logic [6:0] i_byte_index,
    input wire logic [7:0] i_packet_length
);
    import sspd_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_kind) && $stable(i_data_byte)
            && $stable(i_byte_index) && $stable(i_packet_length))
        else $error("result beat changed while stalled");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_kind == KIND_BYTE) || (i_kind == KIND_END) || (i_kind == KIND_DROP))
        else $error("undefined result kind");

    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind == KIND_END) |-> (i_data_byte == 8'd0) && (i_byte_index == 7'd0))
        else $error("packet end carries byte fields");

    a_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind != KIND_END) |-> (i_packet_length == 8'd0)
            && ((i_kind != KIND_DROP) || (i_byte_index == 7'd0)))
        else $error("byte result carries packet end fields");

endmodule

bind sampled_serial_packet_deserializer sspd_checker u_sspd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_out.valid),
    .i_ready         (o_out.ready),
    .i_kind          (o_out.kind),
    .i_data_byte     (o_out.data_byte),
    .i_byte_index    (o_out.byte_index),
    .i_packet_length (o_out.packet_length)
);

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking bench for sampled_serial_packet_deserializer: random and directed wire samples.
// A scoreboard class predicts each result beat, with its own copy of the deglitch filter.
// Depends on sspd_pkg, sspd_if and the deserializer top level.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sspd_pkg::*;

    // Byte capacity of one packet; must match the block's MAX_PACKET_BYTES default.
    localparam int PACKET_CAPACITY = 128;
    // The deglitch register is the only one and lies at byte address 0.
    localparam logic [2:0] DEGLITCH_ADDR = {REG_DEGLITCH_COUNT, 2'b00};
    // Margin for samples still in flight once every predicted beat has left the block.
    localparam int SETTLE_CYCLES = 6;

    // Predicts the deserializer's result beats from the accepted sample beats and
    // compares them, in order, with the beats that leave the block.
    class byte_stream_checker;
        logic [7:0] deglitch;
        logic       last_clock;
        logic       last_packet;
        logic       filt_clock;
        logic       first_pending;
        logic [7:0] countdown;
        logic [7:0] shreg;
        int         bits;
        int         held;
        int         samples;
        int         predicted;
        int         errors;
        t_result    awaited[$];

        function new();
            deglitch      = DEGLITCH_RESET;
            last_clock    = 1'b0;
            last_packet   = 1'b0;
            filt_clock    = 1'b0;
            first_pending = 1'b1;
            countdown     = 8'd0;
            shreg         = 8'd0;
            bits          = 0;
            held          = 0;
            samples       = 0;
            predicted     = 0;
            errors        = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void post(logic [1:0] kind, logic [7:0] data, logic [6:0] index,
                           logic [7:0] length);
            t_result r;
            r.kind          = kind;
            r.data_byte     = data;
            r.byte_index    = index;
            r.packet_length = length;
            awaited.push_back(r);
            predicted++;
        endfunction

        function void take_sample(t_sample s);
            samples++;
            // A rising packet wire starts a fresh bit accumulator.
            if (!last_packet && s.packet_line) begin
                bits  = 0;
                shreg = 8'd0;
            end
            // A falling packet wire closes a packet that holds at least one byte.
            if (last_packet && !s.packet_line && held != 0) begin
                post(KIND_END, 8'd0, 7'd0, 8'(held));
                held        = 0;
                last_clock  = s.clock_line;
                last_packet = 1'b0;
                return;
            end
            if (!s.packet_line) begin
                last_clock  = s.clock_line;
                last_packet = 1'b0;
                return;
            end
            // The very first sample inside a packet only seeds the filter; the packet
            // level is not stored, so the next sample sees the rising edge again.
            if (first_pending) begin
                filt_clock    = s.clock_line;
                last_clock    = s.clock_line;
                first_pending = 1'b0;
                return;
            end
            // Sticky countdown: it is not reloaded when the clock returns to the
            // filtered level. Early returns leave the stored wire levels alone.
            if (s.clock_line != filt_clock) begin
                if (countdown == 8'd0) begin
                    countdown = deglitch;
                    return;
                end
                countdown = countdown - 8'd1;
                if (countdown != 8'd0)
                    return;
                filt_clock = s.clock_line;
            end
            if (!last_clock && s.clock_line) begin
                shreg = shreg | (8'(s.data_line) << (7 - bits));
                bits++;
                if (bits == 8) begin
                    if (held >= PACKET_CAPACITY) begin
                        post(KIND_DROP, shreg, 7'd0, 8'd0);
                    end else begin
                        post(KIND_BYTE, shreg, 7'(held), 8'd0);
                        held++;
                    end
                    bits  = 0;
                    shreg = 8'd0;
                end
            end
            last_clock  = s.clock_line;
            last_packet = s.packet_line;
        endfunction

        function void match_result(t_result got);
            t_result want;
            if (awaited.size() == 0) begin
                $error("result beat with no expectation waiting: kind %0d byte %0h",
                       got.kind, got.data_byte);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                errors++;
            end
            if (got.data_byte !== want.data_byte) begin
                $error("data_byte: expected %0h, got %0h", want.data_byte, got.data_byte);
                errors++;
            end
            if (got.byte_index !== want.byte_index) begin
                $error("byte_index: expected %0d, got %0d", want.byte_index, got.byte_index);
                errors++;
            end
            if (got.packet_length !== want.packet_length) begin
                $error("packet_length: expected %0d, got %0d",
                       want.packet_length, got.packet_length);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    // When set, neither side idles: used for the long stretch at full rate.
    bit          steady;

    byte_stream_checker book = new();

    sspd_in_if  in_ch ();
    sspd_out_if out_ch ();

    sampled_serial_packet_deserializer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // The result side stalls at random, with a chance of 36 in a hundred, except in steady stretches.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= steady || ($urandom_range(0, 99) >= 36);
        end
    end

    // Result beats are taken at the rising edge; the values seen here are those from
    // before the edge, since everything we drive changes on the falling edge.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            book.match_result({out_ch.kind, out_ch.data_byte, out_ch.byte_index,
                               out_ch.packet_length});
    end

    // Hands one sample beat to the block, idling at random beforehand. The valid line is
    // left high after the beat is taken so that back-to-back beats need no extra cycle.
    task automatic send_sample(input logic c, input logic d, input logic p);
        t_sample s;
        s.clock_line  = c;
        s.data_line   = d;
        s.packet_line = p;
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < 36) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.clock_line  <= c;
        in_ch.data_line   <= d;
        in_ch.packet_line <= p;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        book.take_sample(s);
    endtask

    // Samples with the packet wire low; clock and data wander freely.
    task automatic packet_gap(input int n);
        repeat (n)
            send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
    endtask

    task automatic noise_burst(input int n);
        repeat (n)
            send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
    endtask

    // One serial bit inside a packet: the clock low for hold samples, then high for hold
    // samples with the data bit steady. Noisy bits carry occasional one-sample glitches.
    task automatic send_bit(input logic d, input int hold, input bit noisy);
        logic c;
        for (int half = 0; half < 2; half++) begin
            for (int k = 0; k < hold; k++) begin
                c = (half == 1);
                if (noisy && $urandom_range(0, 15) == 0)
                    c = ~c;
                send_sample(c, (half == 1) ? d : 1'($urandom_range(0, 1)), 1'b1);
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] value, input int hold, input bit noisy);
        for (int i = 7; i >= 0; i--)
            send_bit(value[i], hold, noisy);
    endtask

    // A well-formed packet with random content, sometimes with a trailing partial byte
    // that the next packet's rising edge must discard.
    task automatic random_packet(input int hold, input bit noisy);
        packet_gap($urandom_range(1, 3));
        repeat ($urandom_range(0, 3))
            send_byte(8'($urandom), hold, noisy);
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 7))
                send_bit(1'($urandom_range(0, 1)), hold, noisy);
        end
        packet_gap($urandom_range(1, 2));
    endtask

    // Stops sending and waits until every predicted beat has left the block, then waits out
    // the settle margin in case the last samples are still in flight without a result.
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES)
            @(posedge i_clk);
    endtask

    // One APB transfer: setup cycle, then the access cycle, completed when pready is high.
    task automatic apb_access(input logic write, input logic [7:0] value,
                              output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= DEGLITCH_ADDR;
        pwdata  <= {24'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic read_back(input logic [7:0] want);
        logic [31:0] rd;
        apb_access(1'b0, 8'd0, rd);
        if (rd[7:0] !== want) begin
            $error("deglitch_count: expected %0d, got %0d", want, rd[7:0]);
            book.errors++;
        end
    endtask

    // The register is only written once the block has gone quiet.
    task automatic set_deglitch(input logic [7:0] value);
        logic [31:0] rd;
        drain();
        apb_access(1'b1, value, rd);
        book.deglitch = value;
        read_back(value);
    endtask

    // A stretch of random traffic at one deglitch setting: mostly well-formed packets,
    // with noise bursts, packets whose clock may be held too briefly, and full pauses.
    task automatic random_phase(input logic [7:0] dg, input bit calm);
        int first_sample;
        int hold;
        set_deglitch(dg);
        steady       = calm;
        first_sample = book.samples;
        while (book.samples - first_sample < 180) begin
            hold = dg + 1 + $urandom_range(0, 2);
            case ($urandom_range(0, 9))
                7: noise_burst($urandom_range(1, 20));
                8: begin
                    packet_gap(1);
                    repeat ($urandom_range(1, 2))
                        send_byte(8'($urandom), $urandom_range(1, dg + 1), 1'b1);
                    packet_gap(1);
                end
                9: drain();
                default: random_packet(hold, $urandom_range(0, 2) == 0);
            endcase
        end
        steady = 1'b0;
    endtask

    initial begin
        in_ch.valid       = 1'b0;
        in_ch.clock_line  = 1'b0;
        in_ch.data_line   = 1'b0;
        in_ch.packet_line = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = 3'd0;
        pwdata            = 32'd0;
        steady            = 1'b0;
        i_rst_n           = 1'b0;
        repeat (8)
            @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The register must come out of reset at its documented value.
        read_back(DEGLITCH_RESET);

        // Reset setting: the first high packet sample only seeds the filter. Then bytes of
        // all ones and all zeros, an empty packet that must stay silent, a glitchy byte,
        // and a partial byte cut off by the end of the packet.
        packet_gap(2);
        send_byte(8'hFF, 6, 1'b0);
        send_byte(8'h00, 7, 1'b0);
        packet_gap(2);
        repeat (3)
            send_sample(1'b0, 1'b1, 1'b1);
        packet_gap(1);
        send_byte(8'hA5, 8, 1'b1);
        repeat (3)
            send_bit(1'b1, 6, 1'b0);
        packet_gap(2);

        // Smallest setting: two differing samples accept an edge.
        set_deglitch(8'd1);
        packet_gap(1);
        send_byte(8'h80, 2, 1'b0);
        send_byte(8'h01, 2, 1'b0);
        packet_gap(1);

        // Largest setting: a single bit, each clock edge needing 256 differing samples.
        set_deglitch(8'd255);
        packet_gap(2);
        send_bit(1'b1, 256, 1'b0);
        packet_gap(2);

        // Zero setting: clock changes are never accepted, so nothing may come out.
        set_deglitch(8'd0);
        noise_burst(40);
        random_packet(3, 1'b0);

        random_phase(8'd2, 1'b0);
        random_phase(8'd3, 1'b1);
        random_phase(8'($urandom_range(1, 4)), 1'b0);

        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES)
            @(posedge i_clk);
        if (book.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Safety net: ends a hung run with an error; a correct run finishes well before the limit.
    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
